// ===== rtl/dpf_pkg.sv =====
package dpf_pkg;

	localparam int KIND_W = 2;
	localparam int LIM_W  = 9;
	localparam int CNT_W  = 9;

	localparam logic [LIM_W-1:0] LIMIT_RESET = 9'd256;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD = 2'd0,
		KIND_FWD = 2'd1,
		KIND_CNT = 2'd2
	} kind_t;

	// per-entry verdict from the shared compare unit
	typedef struct packed {
		logic vld;
		logic dup;
		logic in_rng;
	} cmp_res_t;

endpackage

// ===== rtl/dpf_store.sv =====
module dpf_store import dpf_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int PW    = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [PW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [PW-1:0]            rdata
);

	logic [PW-1:0] mem_q [DEPTH];
	logic [PW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/dpf_cmp.sv =====
module dpf_cmp import dpf_pkg::*; #(
	parameter int ID_BITS   = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld,
	input  logic [ID_BITS-1:0]   ent_src,
	input  logic [ID_BITS-1:0]   ent_dst,
	input  logic [TIME_BITS-1:0] ent_ts,
	input  logic [ID_BITS-1:0]   key_src,
	input  logic [ID_BITS-1:0]   key_dst,
	input  logic [TIME_BITS-1:0] key_ts,
	input  logic [TIME_BITS-1:0] key_lo,
	input  logic [TIME_BITS-1:0] key_hi,
	output cmp_res_t             res
);

	cmp_res_t res_q;
	logic     dst_eq;

	assign dst_eq = (ent_dst == key_dst);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else begin
			res_q.vld    <= vld;
			res_q.dup    <= dst_eq && (ent_src == key_src) && (ent_ts == key_ts);
			res_q.in_rng <= dst_eq && (ent_ts >= key_lo) && (ent_ts <= key_hi);
		end
	end

	assign res = res_q;

endmodule

// ===== rtl/dedup_packet_fifo_with_range_count.sv =====
// Bounded FIFO packet buffer with duplicate filter and range count. One item is taken when
// start is high and busy is low; busy then stays high until the cycle in which its single
// result is shown on the result ports under done, and the receiver must take it then (a new
// item may be taken in that same cycle). Add and count walk every stored packet through one
// shared compare unit, one entry per cycle from the single read port of the packet memory;
// forward reads only the oldest entry, and add or count on an empty buffer and the unused
// kind go straight to the result. memory_limit may be written at any idle time and takes
// effect on the next add; a limit of 0 acts as 1 and one above DEPTH acts as DEPTH. No
// clearing pass follows reset.
module dedup_packet_fifo_with_range_count import dpf_pkg::*; #(
	parameter int DEPTH     = 256,
	parameter int ID_BITS   = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [LIM_W-1:0]     cfg_wdata,
	input  logic                 start,
	output logic                 busy,
	input  logic [KIND_W-1:0]    kind,
	input  logic [ID_BITS-1:0]   source,
	input  logic [ID_BITS-1:0]   destination,
	input  logic [TIME_BITS-1:0] timestamp,
	input  logic [TIME_BITS-1:0] start_time,
	input  logic [TIME_BITS-1:0] end_time,
	output logic                 done,
	output logic                 accepted,
	output logic                 forward_valid,
	output logic [ID_BITS-1:0]   out_source,
	output logic [ID_BITS-1:0]   out_destination,
	output logic [TIME_BITS-1:0] out_timestamp,
	output logic [CNT_W-1:0]     match_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int LW = (FW > LIM_W) ? FW : LIM_W;
	localparam int PW = 2 * ID_BITS + TIME_BITS;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_DRAIN = 5'b00100,
		S_FWD   = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t                state_q;
	logic [KIND_W-1:0]     kind_q;
	logic [ID_BITS-1:0]    src_q;
	logic [ID_BITS-1:0]    dst_q;
	logic [TIME_BITS-1:0]  ts_q;
	logic [TIME_BITS-1:0]  lo_q;
	logic [TIME_BITS-1:0]  hi_q;
	logic [AW-1:0]         head_q;
	logic [AW-1:0]         tail_q;
	logic [AW-1:0]         scan_q;
	logic [FW-1:0]         fill_q;
	logic [FW-1:0]         left_q;
	logic [FW-1:0]         cnt_q;
	logic                  dup_q;
	logic [LIM_W-1:0]      limit_q;
	logic                  rd_vld_s1;
	logic                  done_q;
	logic                  accepted_q;
	logic                  fwd_vld_q;
	logic [ID_BITS-1:0]    osrc_q;
	logic [ID_BITS-1:0]    odst_q;
	logic [TIME_BITS-1:0]  ots_q;
	logic [CNT_W-1:0]      mcnt_q;

	logic                  take;
	logic                  mem_we;
	logic                  mem_re;
	logic [AW-1:0]         mem_raddr;
	logic [PW-1:0]         mem_rdata;
	logic [ID_BITS-1:0]    ent_src;
	logic [ID_BITS-1:0]    ent_dst;
	logic [TIME_BITS-1:0]  ent_ts;
	logic [LW-1:0]         lim_eff;
	logic                  full;
	cmp_res_t              cmp_res;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign busy = (state_q != S_IDLE);
	assign take = start && !busy;

	always_comb begin
		if (limit_q == '0) begin
			lim_eff = LW'(1);
		end else if (LW'(limit_q) > LW'(DEPTH)) begin
			lim_eff = LW'(DEPTH);
		end else begin
			lim_eff = LW'(limit_q);
		end
	end

	assign full = (LW'(fill_q) >= lim_eff);

	assign mem_re    = (state_q == S_SCAN) || (state_q == S_FWD);
	assign mem_raddr = (state_q == S_SCAN) ? scan_q : head_q;
	assign mem_we    = (state_q == S_FIN) && (kind_q == KIND_ADD) && !dup_q;
	assign {ent_src, ent_dst, ent_ts} = mem_rdata;

	dpf_store #(
		.DEPTH (DEPTH),
		.PW    (PW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (tail_q),
		.wdata ({src_q, dst_q, ts_q}),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	dpf_cmp #(
		.ID_BITS   (ID_BITS),
		.TIME_BITS (TIME_BITS)
	) u_cmp (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (rd_vld_s1),
		.ent_src (ent_src),
		.ent_dst (ent_dst),
		.ent_ts  (ent_ts),
		.key_src (src_q),
		.key_dst (dst_q),
		.key_ts  (ts_q),
		.key_lo  (lo_q),
		.key_hi  (hi_q),
		.res     (cmp_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			kind_q     <= '0;
			src_q      <= '0;
			dst_q      <= '0;
			ts_q       <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			scan_q     <= '0;
			fill_q     <= '0;
			left_q     <= '0;
			cnt_q      <= '0;
			dup_q      <= 1'b0;
			rd_vld_s1  <= 1'b0;
			done_q     <= 1'b0;
			accepted_q <= 1'b0;
			fwd_vld_q  <= 1'b0;
			osrc_q     <= '0;
			odst_q     <= '0;
			ots_q      <= '0;
			mcnt_q     <= '0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= (state_q == S_SCAN);

			// fold in the verdict for each entry leaving the compare unit
			if (cmp_res.vld) begin
				dup_q <= dup_q | cmp_res.dup;
				cnt_q <= cnt_q + FW'(cmp_res.in_rng);
			end

			case (state_q)
				S_IDLE: begin
					if (take) begin
						kind_q <= kind;
						src_q  <= source;
						dst_q  <= destination;
						ts_q   <= timestamp;
						lo_q   <= start_time;
						hi_q   <= end_time;
						dup_q  <= 1'b0;
						cnt_q  <= '0;
						scan_q <= head_q;
						left_q <= fill_q;
						case (kind)
							KIND_ADD, KIND_CNT: begin
								state_q <= (fill_q == '0) ? S_FIN : S_SCAN;
							end
							KIND_FWD: begin
								state_q <= (fill_q == '0) ? S_FIN : S_FWD;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_SCAN: begin
					scan_q <= nxt(scan_q);
					left_q <= left_q - 1'b1;
					if (left_q == FW'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// wait for the last reads to clear the compare pipe
					if (!rd_vld_s1 && !cmp_res.vld) begin
						state_q <= S_FIN;
					end
				end
				S_FWD: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					done_q     <= 1'b1;
					accepted_q <= 1'b0;
					fwd_vld_q  <= 1'b0;
					osrc_q     <= '0;
					odst_q     <= '0;
					ots_q      <= '0;
					mcnt_q     <= '0;
					case (kind_q)
						KIND_ADD: begin
							if (!dup_q) begin
								accepted_q <= 1'b1;
								tail_q     <= nxt(tail_q);
								// at the limit the oldest goes, so the level holds
								if (full) begin
									head_q <= nxt(head_q);
								end else begin
									fill_q <= fill_q + 1'b1;
								end
							end
						end
						KIND_FWD: begin
							if (fill_q != '0) begin
								fwd_vld_q <= 1'b1;
								osrc_q    <= ent_src;
								odst_q    <= ent_dst;
								ots_q     <= ent_ts;
								head_q    <= nxt(head_q);
								fill_q    <= fill_q - 1'b1;
							end
						end
						KIND_CNT: begin
							mcnt_q <= CNT_W'(cnt_q);
						end
						default: begin
						end
					endcase
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done            = done_q;
	assign accepted        = accepted_q;
	assign forward_valid   = fwd_vld_q;
	assign out_source      = osrc_q;
	assign out_destination = odst_q;
	assign out_timestamp   = ots_q;
	assign match_count     = mcnt_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH))
		else $error("fill level beyond depth");

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (!rd_vld_s1 && !cmp_res.vld))
		else $error("compare pipe busy while idle");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> (done && !busy))
		else $error("result not issued after finish");

	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot0({accepted, forward_valid}))
		else $error("add and forward flags both set");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (busy && !done))
		else $error("item taken but block not busy");

endmodule
